// ===== hdl/fixed_string_word_matcher_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Fixed string word matcher assertion macros
// Property shorthands for the matcher's concurrent checks. They expect clk
// and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef FIXED_STRING_WORD_MATCHER_UNIT_MACROS_SVH
`define FIXED_STRING_WORD_MATCHER_UNIT_MACROS_SVH

// same-cycle implication
`define FSW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FSW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fsw_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed string word matcher package
// Sizes, configuration types and character helpers shared by the matcher.
// ----------------------------------------------------------------------------
package fsw_pkg;

  localparam int MAX_PATTERN  = 8;
  localparam int HIST_DEPTH   = MAX_PATTERN + 1;
  localparam int HIST_W       = $clog2(HIST_DEPTH);
  localparam int FILL_W       = $clog2(HIST_DEPTH + 1);
  localparam int SINCE_TOP    = (MAX_PATTERN > 15) ? MAX_PATTERN : 15;
  localparam int SINCE_W      = $clog2(SINCE_TOP + 1);
  localparam int PAT_IDX_W    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int PAT_REG_BITS = 64;
  localparam int PAT_REG_BYTES = PAT_REG_BITS / 8;
  localparam int LEN_W        = 4;
  localparam int COUNT_W      = 16;
  localparam int CFG_IDX_W    = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_BYTES  = 2'd0,
    CFG_PATTERN_LENGTH = 2'd1,
    CFG_FOLD_CASE      = 2'd2,
    CFG_WHOLE_WORDS    = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [PAT_REG_BITS-1:0] pattern_bytes;
    logic [LEN_W-1:0]        pattern_length;
    logic                    fold_case;
    logic                    whole_words;
  } fsw_cfg_t;

  typedef struct packed {
    logic               found;
    logic [COUNT_W-1:0] line_count;
    logic               line_hit;
  } fsw_result_t;

  // ASCII letters only
  function automatic logic is_letter(logic [7:0] c);
    return (c inside {[8'h41:8'h5A]}) || (c inside {[8'h61:8'h7A]});
  endfunction

  function automatic logic [7:0] to_upper(logic [7:0] c);
    return (c inside {[8'h61:8'h7A]}) ? c - 8'h20 : c;
  endfunction

endpackage

// ===== hdl/fsw_cfg.sv =====
// ----------------------------------------------------------------------------
// Fixed string word matcher configuration registers
// Register file behind the write channel; always ready.
// ----------------------------------------------------------------------------
module fsw_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fsw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fsw_pkg::PAT_REG_BITS-1:0] cfg_wdata,
  output fsw_pkg::fsw_cfg_t               cfg_o
);
  import fsw_pkg::*;

  fsw_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_bytes  <= '0;
      cfg_r.pattern_length <= LEN_W'(1);
      cfg_r.fold_case      <= 1'b0;
      cfg_r.whole_words    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        CFG_PATTERN_BYTES:  cfg_r.pattern_bytes  <= cfg_wdata;
        CFG_PATTERN_LENGTH: cfg_r.pattern_length <= cfg_wdata[LEN_W-1:0];
        CFG_FOLD_CASE:      cfg_r.fold_case      <= cfg_wdata[0];
        CFG_WHOLE_WORDS:    cfg_r.whole_words    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/fsw_core.sv =====
// ----------------------------------------------------------------------------
// Fixed string word matcher core
// Line state, window compare against the pattern and whole-word check.
// Result is combinational from the state and the current item.
// ----------------------------------------------------------------------------
module fsw_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            text_byte,
  input  logic                  line_end,
  input  fsw_pkg::fsw_cfg_t     cfg,
  output fsw_pkg::fsw_result_t  result
);
  import fsw_pkg::*;

  logic [7:0]         hist_r   [HIST_DEPTH];
  logic [7:0]         hist_nxt [HIST_DEPTH];
  logic [FILL_W-1:0]  fill_r,  fill_nxt;
  logic [SINCE_W-1:0] since_r, since_nxt;
  logic [COUNT_W-1:0] hits_r,  hits_nxt;
  logic               any_r,   any_nxt;

  logic [7:0]       pat_b [MAX_PATTERN];
  logic [LEN_W-1:0] len;
  logic             all_eq;
  logic             consumed;
  logic             reported;
  logic             before_letter;
  logic             cur_letter;
  logic [7:0]       last_pat;

  // bytes past the register read as zero
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pat
    if (k < PAT_REG_BYTES) begin : g_reg
      assign pat_b[k] = cfg.pattern_bytes[8*k +: 8];
    end else begin : g_zero
      assign pat_b[k] = 8'h00;
    end
  end

  always_comb begin
    if (cfg.pattern_length == '0) begin
      len = LEN_W'(1);
    end else if (int'(cfg.pattern_length) > MAX_PATTERN) begin
      len = LEN_W'(MAX_PATTERN);
    end else begin
      len = cfg.pattern_length;
    end
  end

  // window compare: pattern byte k against the byte len-1-k back
  always_comb begin
    logic [7:0]        p;
    logic [7:0]        t;
    logic [HIST_W-1:0] idx;
    all_eq = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      idx = HIST_W'(int'(len) - 1 - k);
      p   = pat_b[k];
      t   = (k < int'(len)) ? hist_r[idx] : 8'h00;
      if (cfg.fold_case) begin
        p = to_upper(p);
        t = to_upper(t);
      end
      if (k < int'(len) && p != t) begin
        all_eq = 1'b0;
      end
    end
  end

  assign cur_letter    = !line_end && is_letter(text_byte);
  assign last_pat      = pat_b[PAT_IDX_W'(len - LEN_W'(1))];
  assign before_letter = (int'(fill_r) > int'(len)) && is_letter(hist_r[HIST_W'(len)]);
  assign consumed      = (int'(fill_r) >= int'(len)) && (int'(since_r) >= int'(len)) && all_eq;
  assign reported      = consumed && !(cfg.whole_words &&
                           ((is_letter(pat_b[0]) && before_letter) ||
                            (is_letter(last_pat) && cur_letter)));

  always_comb begin
    logic [SINCE_W-1:0] since_base;
    since_base = consumed ? '0 : since_r;
    hits_nxt   = (reported && hits_r != '1) ? hits_r + COUNT_W'(1) : hits_r;
    any_nxt    = any_r || reported;

    result.found      = reported;
    result.line_count = hits_nxt;
    result.line_hit   = line_end && any_nxt;

    hist_nxt[0] = text_byte;
    for (int i = 1; i < HIST_DEPTH; i++) begin
      hist_nxt[i] = hist_r[i-1];
    end
    fill_nxt  = (int'(fill_r) < HIST_DEPTH) ? fill_r + FILL_W'(1) : fill_r;
    since_nxt = (int'(since_base) < SINCE_TOP) ? since_base + SINCE_W'(1) : since_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_r[i] <= 8'h00;
      end
      fill_r  <= '0;
      since_r <= SINCE_W'(SINCE_TOP);
      hits_r  <= '0;
      any_r   <= 1'b0;
    end else if (step) begin
      if (line_end) begin
        for (int i = 0; i < HIST_DEPTH; i++) begin
          hist_r[i] <= 8'h00;
        end
        fill_r  <= '0;
        since_r <= SINCE_W'(SINCE_TOP);
        hits_r  <= '0;
        any_r   <= 1'b0;
      end else begin
        hist_r  <= hist_nxt;
        fill_r  <= fill_nxt;
        since_r <= since_nxt;
        hits_r  <= hits_nxt;
        any_r   <= any_nxt;
      end
    end
  end

endmodule

// ===== hdl/fixed_string_word_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// Fixed string word matcher unit
// Streams text bytes and reports leftmost non-overlapping pattern hits.
// ----------------------------------------------------------------------------
// One line byte (or a line terminator) goes in per transfer and exactly one
// result comes out per item; it passes the input register and the result
// register and waits there until the output is free. Throughput is one item
// per clock while the output is taken: the whole window compare, whole-word
// check and line state update are combinational between the two registers,
// limited by the 8-byte compare plus the count increment. A hit that ends at
// byte n is reported on item n+1 (or on the terminator). found, line_count
// (saturating at 65535) and, on the terminator item only, line_hit form the
// result. Configuration writes are taken every cycle and apply to the next
// compare; write them only while no item is in flight.
`include "fixed_string_word_matcher_unit_macros.svh"

module fixed_string_word_matcher_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fsw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fsw_pkg::PAT_REG_BITS-1:0] cfg_wdata,
  // text input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_text_byte,
  input  logic                             in_line_end,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_found,
  output logic [fsw_pkg::COUNT_W-1:0]      out_line_count,
  output logic                             out_line_hit
);
  import fsw_pkg::*;

  fsw_cfg_t    cfg;
  fsw_result_t res;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;
  logic       s1_adv;

  // result register
  logic               out_valid_r;
  logic               out_found_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_hit_r;

  fsw_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // the held item moves on when the result slot is empty or being drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_text_byte;
      s1_end_r  <= in_line_end;
    end
  end

  // compare and line state; state advances on each processed item
  fsw_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv),
    .text_byte (s1_byte_r),
    .line_end  (s1_end_r),
    .cfg       (cfg),
    .result    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_found_r <= res.found;
      out_count_r <= res.line_count;
      out_hit_r   <= res.line_hit;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_line_count = out_count_r;
  assign out_line_hit   = out_hit_r;

  // a reported hit is always counted
  `FSW_ASSERT_IMP(a_found_counted, out_valid_r && out_found_r, out_count_r != '0, "found without count")
  // a line with a hit has a nonzero total
  `FSW_ASSERT_IMP(a_hit_counted, out_valid_r && out_hit_r, out_count_r != '0, "line_hit without count")
  // a processed item always lands in the result register
  `FSW_ASSERT_NXT(a_adv_lands, s1_adv, out_valid_r, "processed item lost")

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Fixed string word matcher testbench
// Streams text lines through the matcher under a series of register settings
// and checks every result against a cycle-free scan model of the search.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fsw_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_PAUSE = 8;     // result register sits two stages out

  typedef struct packed {
    logic [7:0] text_byte;
    logic       line_end;
  } text_item_t;

  // DUT ports; every input starts at a known value
  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [PAT_REG_BITS-1:0] cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [7:0]              in_text_byte = '0;
  logic                    in_line_end = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    out_found;
  logic [COUNT_W-1:0]      out_line_count;
  logic                    out_line_hit;

  // stimulus and scoreboard storage
  text_item_t  text_items[$];       // bytes waiting for the driver
  fsw_result_t expected_results[$]; // predicted results, oldest first
  text_item_t  next_item;
  fsw_result_t want;
  logic        no_idle = 1'b0;      // both sides run flat out when set
  int          cycle_count = 0;
  int          error_count = 0;
  int          results_seen = 0;
  int          hits_seen = 0;
  int          phase_count = 0;
  int          queued_count = 0;

  // scan model: register mirror and line state
  logic [63:0] m_pattern;
  logic [3:0]  m_length;
  logic        m_fold;
  logic        m_whole;
  logic [7:0]  line_hist[HIST_DEPTH]; // newest byte at index 0
  int          line_fill;
  int          since_hit;
  logic [15:0] hit_total;
  logic        line_any;

  fixed_string_word_matcher_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_text_byte  (in_text_byte),
    .in_line_end   (in_line_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_found     (out_found),
    .out_line_count(out_line_count),
    .out_line_hit  (out_line_hit)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Scan model
  // ---------------------------------------------------------------------------
  function automatic logic alpha_q(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic [7:0] fold_up(logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A) return c - 8'h20;
    return c;
  endfunction

  // length register as the compare sees it: 0 acts as 1, clipped at the top
  function automatic int eff_length();
    if (m_length == 4'd0) return 1;
    if (int'(m_length) > MAX_PATTERN) return MAX_PATTERN;
    return int'(m_length);
  endfunction

  // positions past the 64-bit register read as zero
  function automatic logic [7:0] pat_at(int k);
    if (k >= PAT_REG_BYTES) return 8'h00;
    return m_pattern[8*k +: 8];
  endfunction

  function automatic void clear_line();
    foreach (line_hist[i]) line_hist[i] = 8'h00;
    line_fill = 0;
    since_hit = SINCE_TOP;
    hit_total = '0;
    line_any  = 1'b0;
  endfunction

  // Occurrence ending at the previous byte: consumed on a match, counted only
  // if the whole-word rule lets it through.
  function automatic logic consume_hit(logic next_alpha);
    int         len;
    logic [7:0] p;
    logic [7:0] t;
    logic       pre_alpha;
    logic       ok;
    len = eff_length();
    if (line_fill < len || since_hit < len) return 1'b0;
    for (int k = 0; k < len; k++) begin
      p = pat_at(k);
      t = line_hist[len-1-k];
      if (m_fold) begin
        p = fold_up(p);
        t = fold_up(t);
      end
      if (p != t) return 1'b0;
    end
    since_hit = 0;
    ok = 1'b1;
    if (m_whole) begin
      pre_alpha = (line_fill > len) && alpha_q(line_hist[len]);
      if (alpha_q(pat_at(0)) && pre_alpha) ok = 1'b0;
      if (alpha_q(pat_at(len-1)) && next_alpha) ok = 1'b0;
    end
    if (ok) begin
      if (hit_total != 16'hFFFF) hit_total++;
      line_any = 1'b1;
    end
    return ok;
  endfunction

  function automatic fsw_result_t match_next(logic [7:0] c, logic eol);
    fsw_result_t r;
    // terminator counts as a non-letter neighbor
    r.found      = consume_hit(eol ? 1'b0 : alpha_q(c));
    r.line_count = hit_total;
    r.line_hit   = eol ? line_any : 1'b0;
    if (eol) begin
      clear_line();
    end else begin
      for (int k = HIST_DEPTH - 1; k > 0; k--) line_hist[k] = line_hist[k-1];
      line_hist[0] = c;
      if (line_fill < HIST_DEPTH) line_fill++;
      if (since_hit < SINCE_TOP) since_hit++;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Text driver: one transfer per accepted item, prediction taken at accept
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(match_next(in_text_byte, in_line_end));
      end
      // payload is held while a transfer is pending
      if (!in_valid || in_ready) begin
        if (text_items.size() != 0 && (no_idle || $urandom_range(99) >= 32)) begin
          next_item = text_items.pop_front();
          in_valid     <= 1'b1;
          in_text_byte <= next_item.text_byte;
          in_line_end  <= next_item.line_end;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each transfer with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_found) hits_seen++;
        if (expected_results.size() == 0) begin
          $display("%t: result with nothing expected: found=%0b count=%0d hit=%0b",
                   $realtime, out_found, out_line_count, out_line_hit);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_found !== want.found) begin
            $display("%t: found mismatch: expected %0b actual %0b",
                     $realtime, want.found, out_found);
            error_count++;
          end
          if (out_line_count !== want.line_count) begin
            $display("%t: line_count mismatch: expected %0d actual %0d",
                     $realtime, want.line_count, out_line_count);
            error_count++;
          end
          if (out_line_hit !== want.line_hit) begin
            $display("%t: line_hit mismatch: expected %0b actual %0b",
                     $realtime, want.line_hit, out_line_hit);
            error_count++;
          end
        end
      end
      out_ready <= no_idle || ($urandom_range(99) >= 32);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending",
               cycle_count, expected_results.size());
      $display("fixed_string_word_matcher_unit verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // one register write; mirror updates at the accepting edge
  task automatic write_reg(cfg_index_t idx, logic [63:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_PATTERN_BYTES:  m_pattern = data;
      CFG_PATTERN_LENGTH: m_length  = data[3:0];
      CFG_FOLD_CASE:      m_fold    = data[0];
      CFG_WHOLE_WORDS:    m_whole   = data[0];
      default: ;
    endcase
  endtask

  // upper bits of the narrow registers carry junk on purpose
  task automatic write_all(logic [63:0] pat, logic [3:0] len, logic fold, logic whole);
    write_reg(CFG_PATTERN_BYTES, pat);
    write_reg(CFG_PATTERN_LENGTH, {$urandom, 28'($urandom_range(15)), len});
    write_reg(CFG_FOLD_CASE, {$urandom, 31'($urandom), 1'b0} | 64'(fold));
    write_reg(CFG_WHOLE_WORDS, {$urandom, 31'($urandom), 1'b0} | 64'(whole));
    phase_count++;
  endtask

  // wait out every pending transfer, then let the pipe settle
  task automatic drain();
    while (text_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic queue_byte(logic [7:0] c);
    text_items.push_back('{text_byte: c, line_end: 1'b0});
    queued_count++;
  endtask

  // terminator byte is don't-care, so randomize it
  task automatic queue_end();
    text_items.push_back('{text_byte: 8'($urandom), line_end: 1'b1});
    queued_count++;
  endtask

  // pattern byte, case flipped at random when folding is on
  function automatic logic [7:0] vary(logic [7:0] c);
    if (m_fold && alpha_q(c) && $urandom_range(1)) return c ^ 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] rand_letter();
    return 8'($urandom_range(25)) + ($urandom_range(1) ? 8'h41 : 8'h61);
  endfunction

  task automatic queue_pattern();
    int el;
    el = eff_length();
    for (int k = 0; k < el; k++) queue_byte(vary(pat_at(k)));
  endtask

  // mostly lines built around the pattern; one in ten is pure noise
  task automatic queue_line();
    int el;
    int frags;
    int n;
    el = eff_length();
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) queue_byte(8'($urandom));
    end else begin
      frags = $urandom_range(1, 6);
      repeat (frags) begin
        case ($urandom_range(11))
          0, 1, 2: queue_pattern();
          3: begin // broken-off prefix
            n = (el > 1) ? $urandom_range(1, el - 1) : 1;
            for (int k = 0; k < n; k++) queue_byte(vary(pat_at(k)));
          end
          4, 5: queue_byte(rand_letter());
          6: begin
            case ($urandom_range(3))
              0: queue_byte(8'h20);
              1: queue_byte(8'h2C);
              2: queue_byte(8'h2D);
              default: queue_byte(8'h2E);
            endcase
          end
          7: queue_byte(8'($urandom));
          8: begin // back to back
            queue_pattern();
            queue_pattern();
          end
          9: begin // letters on both sides
            queue_byte(rand_letter());
            queue_pattern();
            queue_byte(rand_letter());
          end
          10: begin // repeated lead byte ahead of the pattern
            queue_byte(vary(pat_at(0)));
            queue_pattern();
          end
          default: begin
            n = $urandom_range(1, 3);
            repeat (n) queue_byte(8'($urandom));
          end
        endcase
      end
    end
    queue_end();
  endtask

  // random pattern: small alphabet for overlaps, letters, or any byte
  function automatic logic [63:0] rand_pattern();
    logic [7:0]  alphabet[6];
    logic [63:0] p;
    int          mode;
    alphabet = '{8'h61, 8'h41, 8'h62, 8'h42, 8'h20, 8'h2D};
    mode = $urandom_range(3);
    p = {$urandom, $urandom};
    if (mode <= 1) begin
      for (int k = 0; k < 8; k++) p[8*k +: 8] = alphabet[$urandom_range(5)];
    end else if (mode == 2) begin
      for (int k = 0; k < 8; k++) p[8*k +: 8] = rand_letter();
    end
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [3:0] len_pick;
    int         lens[5];
    string      word_line;
    lens = '{0, 8, 15, 1, 2};

    // mirror the reset state of the block
    m_pattern = '0;
    m_length  = 4'd1;
    m_fold    = 1'b0;
    m_whole   = 1'b0;
    clear_line();

    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: single zero byte pattern
    @(negedge clk);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_end();
    drain();

    // "Cat" folded, whole words: hit at line start, then rejected inside "cats"
    write_all(64'h0000_0000_0074_6143, 4'd3, 1'b1, 1'b1);
    @(negedge clk);
    word_line = "cat cats";
    foreach (word_line[i]) queue_byte(word_line[i]);
    queue_end();
    drain();

    // exact case, no word rule: partial mismatch then hit found on terminator
    write_all(64'h0000_0000_0074_6143, 4'd3, 1'b0, 1'b0);
    @(negedge clk);
    queue_byte(8'h43);
    queue_byte(8'h43);
    queue_byte(8'h61);
    queue_byte(8'h74);
    queue_end();
    drain();

    // all-ones pattern with an oversized length, clipped to eight bytes
    write_all(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0, 1'b1);
    @(negedge clk);
    repeat (9) queue_byte(8'hFF);
    queue_end();
    drain();

    // random phases; lines sometimes left open across a register change
    for (int p = 0; p < 14; p++) begin
      if (p < 5) begin
        len_pick = 4'(lens[p]);
      end else if ($urandom_range(9) < 7) begin
        len_pick = 4'($urandom_range(1, 4));
      end else begin
        len_pick = 4'($urandom_range(15));
      end
      write_all(rand_pattern(), len_pick, 1'($urandom_range(1)), 1'($urandom_range(1)));
      @(negedge clk);
      no_idle = (p == 6);
      queued_count = 0;
      while (queued_count < 95) queue_line();
      if ($urandom_range(1)) queue_pattern();
      drain();
    end
    no_idle = 1'b0;

    $display("%0d results checked over %0d register settings, %0d hits reported",
             results_seen, phase_count, hits_seen);
    $display("covered case folding, whole-word rule, length clipping and open lines");
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("fixed_string_word_matcher_unit verification clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("fixed_string_word_matcher_unit verification failed");
    end
    $finish;
  end

endmodule
